// File: rtl/epr_pkg.sv
// Shared types, constants and helper functions of the equatorial precession rotate unit.
package epr_pkg;

    localparam int CORDIC_STAGES = 30;
    localparam int STAGE_W = $clog2(CORDIC_STAGES);
    localparam int VEC_W = 36;
    localparam int ANG_W = 35;

    localparam logic signed [VEC_W-1:0] GAIN_Q30 = 36'sd652032874;
    localparam logic signed [VEC_W-1:0] ONE_Q30 = 36'sd1073741824;
    localparam logic signed [VEC_W-1:0] POLE_LIMIT = 36'sd256;
    localparam logic signed [31:0] DEC_LIMIT = 32'sd1073741824;
    localparam logic signed [ANG_W-1:0] HALF_TURN = 35'sd2147483648;
    localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;

    localparam logic signed [31:0] LIN_COEF [3] = '{32'sd1956569030, 32'sd1700434437,
                                                   32'sd1956569030};
    localparam logic signed [31:0] SQ_COEF [3] = '{32'sd65599307, -32'sd92652180,
                                                  32'sd237768168};
    localparam logic signed [31:0] CU_COEF [3] = '{32'sd3909375, -32'sd9069749,
                                                  32'sd3987562};

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] r;
    } lane_t;

    typedef struct packed {
        logic             cfg;
        logic             flip;
        logic             pole;
        logic [VEC_W-1:0] aux;
    } side_t;

    typedef struct packed {
        logic [31:0] zeta;
        logic [31:0] theta;
        logic [31:0] z;
    } angles_t;

    typedef logic [31:0] atan_rom_t [CORDIC_STAGES];

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        q = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [31:0] atan_entry(input int i);
        logic [63:0]  acc;
        logic [63:0]  term;
        logic [127:0] prod;
        logic [63:0]  turns;
        int           e;
        acc = '0;
        if (i == 0)
        begin
            return 32'h2000_0000;
        end
        for (int n = 0; n < 32; n++)
        begin
            e = i * (2 * n + 1);
            if (e <= 62)
            begin
                term = udiv64(64'd1 << (62 - e), 64'(2 * n + 1));
                if (n[0])
                begin
                    acc = acc - term;
                end
                else
                begin
                    acc = acc + term;
                end
            end
        end
        prod = {64'd0, acc} * {64'd0, INV_TWO_PI_Q64};
        turns = prod[127:64];
        return 32'((turns + 64'd536870912) >> 30);
    endfunction

    function automatic atan_rom_t build_atan_rom();
        atan_rom_t rom;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            rom[i] = atan_entry(i);
        end
        return rom;
    endfunction

    localparam atan_rom_t ATAN_ROM = build_atan_rom();

    function automatic logic signed [VEC_W-1:0] qmul(input logic signed [VEC_W-1:0] a,
                                                      input logic signed [VEC_W-1:0] b);
        logic signed [2*VEC_W-1:0] p;
        p = a * b + (72'sd1 <<< 29);
        return signed'(p[VEC_W+29:30]);
    endfunction

    // Folds an angle into the right half turn; the caller negates the result when bits
    // 31 and 30 differ.
    function automatic lane_t rot_fold(input logic [31:0] a);
        lane_t l;
        l.x = GAIN_Q30;
        l.y = '0;
        l.r = signed'({{3{a[30]}}, a[30], a[30:0]});
        return l;
    endfunction

    function automatic lane_t vec_fold(input logic signed [VEC_W-1:0] x,
                                       input logic signed [VEC_W-1:0] y);
        lane_t l;
        if (x < 0)
        begin
            l.x = -x;
            l.y = -y;
            l.r = HALF_TURN;
        end
        else
        begin
            l.x = x;
            l.y = y;
            l.r = '0;
        end
        return l;
    endfunction

endpackage

// File: rtl/epr_cordic_cell.sv
// One registered CORDIC micro-rotation, in rotation or vectoring mode.
module epr_cordic_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   vec,
    input  logic [epr_pkg::STAGE_W-1:0] stage,
    input  logic                   valid_i,
    input  epr_pkg::lane_t         lane_i,
    input  epr_pkg::side_t         side_i,
    output logic                   valid_o,
    output epr_pkg::lane_t         lane_o,
    output epr_pkg::side_t         side_o
);
    import epr_pkg::*;

    logic                    valid_reg;
    lane_t                   lane_reg;
    lane_t                   lane_next;
    side_t                   side_reg;
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;
    logic signed [ANG_W-1:0] step_ang;
    logic                    up;

    always_comb
    begin
        xs = lane_i.x >>> stage;
        ys = lane_i.y >>> stage;
        step_ang = signed'({3'b000, ATAN_ROM[stage]});
        up = vec ? (lane_i.y < 0) : (lane_i.r >= 0);
        if (up)
        begin
            lane_next.x = lane_i.x - ys;
            lane_next.y = lane_i.y + xs;
            lane_next.r = lane_i.r - step_ang;
        end
        else
        begin
            lane_next.x = lane_i.x + ys;
            lane_next.y = lane_i.y - xs;
            lane_next.r = lane_i.r + step_ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
            side_reg <= side_i;
        end
    end

    assign valid_o = valid_reg;
    assign lane_o = lane_reg;
    assign side_o = side_reg;

endmodule

// File: rtl/epr_cordic_chain.sv
// A row of CORDIC cells that forms one fully pipelined rotation or vectoring unit.
module epr_cordic_chain (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           vec,
    input  logic           valid_i,
    input  epr_pkg::lane_t lane_i,
    input  epr_pkg::side_t side_i,
    output logic           valid_o,
    output epr_pkg::lane_t lane_o,
    output epr_pkg::side_t side_o
);
    import epr_pkg::*;

    logic  valid_w [CORDIC_STAGES+1];
    lane_t lane_w [CORDIC_STAGES+1];
    side_t side_w [CORDIC_STAGES+1];

    assign valid_w[0] = valid_i;
    assign lane_w[0] = lane_i;
    assign side_w[0] = side_i;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        epr_cordic_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vec     (vec),
            .stage   (STAGE_W'(g)),
            .valid_i (valid_w[g]),
            .lane_i  (lane_w[g]),
            .side_i  (side_w[g]),
            .valid_o (valid_w[g+1]),
            .lane_o  (lane_w[g+1]),
            .side_o  (side_w[g+1])
        );
    end

    assign valid_o = valid_w[CORDIC_STAGES];
    assign lane_o = lane_w[CORDIC_STAGES];
    assign side_o = side_w[CORDIC_STAGES];

endmodule

// File: rtl/epr_angle_setup.sv
// Sequencer that evaluates the zeta, theta and z polynomials on one shared multiplier.
module epr_angle_setup (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [31:0]      span,
    output logic             running,
    output logic             done,
    output epr_pkg::angles_t angles
);
    import epr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_T2, ST_CUBE, ST_T3, ST_L0, ST_Q0, ST_C0,
        ST_L1, ST_Q1, ST_C1, ST_L2, ST_Q2, ST_C2, ST_END
    } step_t;

    step_t              step_reg;
    step_t              step_next;
    logic signed [31:0] s_reg;
    logic signed [31:0] t2_reg;
    logic signed [39:0] t3_reg;
    logic signed [71:0] prod_reg;
    logic signed [71:0] prod_next;
    logic signed [71:0] rnd;
    logic signed [31:0] op_a;
    logic signed [39:0] op_b;
    logic signed [39:0] s_ext;
    logic signed [39:0] t2_ext;
    logic [31:0]        term;
    angles_t            acc_reg;

    always_comb
    begin
        s_ext = signed'({{8{s_reg[31]}}, s_reg});
        t2_ext = signed'({{8{t2_reg[31]}}, t2_reg});
        op_a = '0;
        op_b = '0;
        unique case (step_reg)
            ST_SQ:   begin op_a = s_reg;      op_b = s_ext;  end
            ST_CUBE: begin op_a = t2_reg;     op_b = s_ext;  end
            ST_L0:   begin op_a = LIN_COEF[0]; op_b = s_ext;  end
            ST_Q0:   begin op_a = SQ_COEF[0];  op_b = t2_ext; end
            ST_C0:   begin op_a = CU_COEF[0];  op_b = t3_reg; end
            ST_L1:   begin op_a = LIN_COEF[1]; op_b = s_ext;  end
            ST_Q1:   begin op_a = SQ_COEF[1];  op_b = t2_ext; end
            ST_C1:   begin op_a = CU_COEF[1];  op_b = t3_reg; end
            ST_L2:   begin op_a = LIN_COEF[2]; op_b = s_ext;  end
            ST_Q2:   begin op_a = SQ_COEF[2];  op_b = t2_ext; end
            ST_C2:   begin op_a = CU_COEF[2];  op_b = t3_reg; end
            default: begin op_a = '0;          op_b = '0;     end
        endcase
        prod_next = op_a * op_b;
        rnd = prod_reg + ((step_reg == ST_T3) ? (72'sd1 <<< 23) : (72'sd1 <<< 31));
        term = rnd[63:32];
        step_next = (step_reg == ST_END || step_reg == ST_IDLE) ? ST_IDLE
                                                                : step_t'(step_reg + 4'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
            acc_reg <= '0;
        end
        else if (start)
        begin
            step_reg <= ST_SQ;
            acc_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
            unique case (step_reg)
                ST_Q0, ST_C0, ST_L1: acc_reg.zeta <= acc_reg.zeta + term;
                ST_Q1, ST_C1, ST_L2: acc_reg.theta <= acc_reg.theta + term;
                ST_Q2, ST_C2, ST_END: acc_reg.z <= acc_reg.z + term;
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s_reg <= signed'(span);
        end
        prod_reg <= prod_next;
        if (step_reg == ST_T2)
        begin
            t2_reg <= signed'(rnd[63:32]);
        end
        if (step_reg == ST_T3)
        begin
            t3_reg <= signed'(rnd[63:24]);
        end
    end

    assign running = (step_reg != ST_IDLE);
    assign done = (step_reg == ST_END);
    assign angles = acc_reg;

endmodule

// File: rtl/equatorial_precession_rotate_unit.sv
// Top level of the equatorial precession rotate unit.
// Takes one request per cycle while s_tready is high and returns each result after it passes
// three chains of 30 CORDIC cells plus five registers for the folds, the products and the
// output. A write of span_centuries starts the angle setup: polynomial evaluation on one
// multiplier, then one pass of theta through the sine and cosine chain; s_tready stays low
// until that sine and cosine are captured. tdata of a request holds ra_in then dec_in; tdata
// of a result holds ra_out then dec_out and tuser flags a result on the pole.
module equatorial_precession_rotate_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        span_we,
    input  logic [31:0] span_centuries,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // ra_in [31:0], dec_in [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // ra_out [31:0], dec_out [63:32]
    output logic [0:0]  m_tuser    // at_pole [0]
);
    import epr_pkg::*;

    logic                    en;
    logic                    s_accept;
    logic                    busy_reg;
    logic                    inj_reg;
    logic                    setup_running;
    logic                    setup_done;
    angles_t                 angles;
    logic                    cfg_capture;

    logic                    ent_valid_reg;
    logic                    ent_cfg_reg;
    logic [31:0]             ent_a_reg;
    logic [31:0]             ent_d_reg;

    logic                    a_valid, b_valid, c_valid, d_valid;
    lane_t                   a_lane, b_lane, c_lane, d_lane;
    side_t                   a_side, b_side, c_side, d_side;
    side_t                   a_in_side, b_in_side, c_in_side, d_in_side;

    logic signed [VEC_W-1:0] ca, sa, cd, sd;
    logic signed [VEC_W-1:0] cos_reg, sin_reg;

    logic                    p1_valid_reg;
    logic signed [VEC_W-1:0] p1_cda_reg, p1_yv_reg, p1_sd_reg;
    logic                    p2_valid_reg;
    logic signed [VEC_W-1:0] p2_sdec_reg, p2_xv_reg, p2_yv_reg;
    logic                    pole_near;
    logic                    p4_valid_reg;
    logic signed [VEC_W-1:0] p4_hyp_reg, p4_sdec_reg;
    logic [31:0]             p4_ra_reg;
    logic                    p4_pole_reg;

    logic signed [31:0]      d_ang;
    logic signed [31:0]      dec_next;
    logic                    m_valid_reg;
    logic [31:0]             m_ra_reg;
    logic signed [31:0]      m_dec_reg;
    logic                    m_pole_reg;

    assign en = !m_valid_reg || m_tready;
    assign s_tready = en && !busy_reg;
    assign s_accept = s_tvalid && s_tready;
    assign cfg_capture = en && a_valid && a_side.cfg;

    epr_angle_setup u_setup (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (span_we),
        .span    (span_centuries),
        .running (setup_running),
        .done    (setup_done),
        .angles  (angles)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            inj_reg <= 1'b0;
            ent_valid_reg <= 1'b0;
            ent_cfg_reg <= 1'b0;
            cos_reg <= ONE_Q30;
            sin_reg <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (span_we)
            begin
                busy_reg <= 1'b1;
            end
            else if (cfg_capture && !setup_running)
            begin
                busy_reg <= 1'b0;
            end
            if (setup_done)
            begin
                inj_reg <= 1'b1;
            end
            else if (en)
            begin
                inj_reg <= 1'b0;
            end
            if (cfg_capture)
            begin
                cos_reg <= ca;
                sin_reg <= sa;
            end
            if (en)
            begin
                ent_valid_reg <= s_accept || inj_reg;
                ent_cfg_reg <= inj_reg;
                p1_valid_reg <= a_valid && b_valid && !a_side.cfg;
                p2_valid_reg <= p1_valid_reg;
                p4_valid_reg <= c_valid;
                m_valid_reg <= d_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ent_a_reg <= inj_reg ? angles.theta : s_tdata[31:0] + angles.zeta;
            ent_d_reg <= s_tdata[63:32];
            p1_cda_reg <= qmul(ca, cd);
            p1_yv_reg <= qmul(sa, cd);
            p1_sd_reg <= sd;
            p2_sdec_reg <= qmul(p1_cda_reg, sin_reg) + qmul(cos_reg, p1_sd_reg);
            p2_xv_reg <= qmul(p1_cda_reg, cos_reg) - qmul(sin_reg, p1_sd_reg);
            p2_yv_reg <= p1_yv_reg;
            p4_hyp_reg <= qmul(c_lane.x, GAIN_Q30);
            p4_ra_reg <= c_side.pole ? angles.z : c_lane.r[31:0] + angles.z;
            p4_pole_reg <= c_side.pole;
            p4_sdec_reg <= signed'(c_side.aux);
            m_ra_reg <= d_side.aux[31:0];
            m_dec_reg <= dec_next;
            m_pole_reg <= d_side.pole;
        end
    end

    always_comb
    begin
        a_in_side = '0;
        a_in_side.cfg = ent_cfg_reg;
        a_in_side.flip = ent_a_reg[31] ^ ent_a_reg[30];
        b_in_side = '0;
        b_in_side.flip = ent_d_reg[31] ^ ent_d_reg[30];
    end

    epr_cordic_chain u_rot_ra (
        .clk (clk), .rst_n (rst_n), .en (en), .vec (1'b0),
        .valid_i (ent_valid_reg), .lane_i (rot_fold(ent_a_reg)), .side_i (a_in_side),
        .valid_o (a_valid), .lane_o (a_lane), .side_o (a_side)
    );

    epr_cordic_chain u_rot_dec (
        .clk (clk), .rst_n (rst_n), .en (en), .vec (1'b0),
        .valid_i (ent_valid_reg), .lane_i (rot_fold(ent_d_reg)), .side_i (b_in_side),
        .valid_o (b_valid), .lane_o (b_lane), .side_o (b_side)
    );

    always_comb
    begin
        ca = a_side.flip ? -a_lane.x : a_lane.x;
        sa = a_side.flip ? -a_lane.y : a_lane.y;
        cd = b_side.flip ? -b_lane.x : b_lane.x;
        sd = b_side.flip ? -b_lane.y : b_lane.y;
    end

    always_comb
    begin
        pole_near = (p2_xv_reg <= POLE_LIMIT) && (p2_xv_reg >= -POLE_LIMIT)
                 && (p2_yv_reg <= POLE_LIMIT) && (p2_yv_reg >= -POLE_LIMIT);
        c_in_side = '0;
        c_in_side.pole = pole_near;
        c_in_side.aux = p2_sdec_reg;
    end

    epr_cordic_chain u_vec_ra (
        .clk (clk), .rst_n (rst_n), .en (en), .vec (1'b1),
        .valid_i (p2_valid_reg), .lane_i (vec_fold(p2_xv_reg, p2_yv_reg)),
        .side_i (c_in_side),
        .valid_o (c_valid), .lane_o (c_lane), .side_o (c_side)
    );

    always_comb
    begin
        d_in_side = '0;
        d_in_side.pole = p4_pole_reg;
        d_in_side.flip = p4_sdec_reg[VEC_W-1];
        d_in_side.aux = {{(VEC_W-32){1'b0}}, p4_ra_reg};
    end

    epr_cordic_chain u_vec_dec (
        .clk (clk), .rst_n (rst_n), .en (en), .vec (1'b1),
        .valid_i (p4_valid_reg), .lane_i (vec_fold(p4_hyp_reg, p4_sdec_reg)),
        .side_i (d_in_side),
        .valid_o (d_valid), .lane_o (d_lane), .side_o (d_side)
    );

    always_comb
    begin
        d_ang = signed'(d_lane.r[31:0]);
        if (d_side.pole)
        begin
            dec_next = d_side.flip ? -DEC_LIMIT : DEC_LIMIT;
        end
        else if (d_ang > DEC_LIMIT)
        begin
            dec_next = DEC_LIMIT;
        end
        else if (d_ang < -DEC_LIMIT)
        begin
            dec_next = -DEC_LIMIT;
        end
        else
        begin
            dec_next = d_ang;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {m_dec_reg, m_ra_reg};
    assign m_tuser = m_pole_reg;

    a_pole_dec: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_dec_reg == DEC_LIMIT || m_dec_reg == -DEC_LIMIT))
        else $error("Pole result without a declination of a quarter turn.");

    a_dec_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_dec_reg <= DEC_LIMIT && m_dec_reg >= -DEC_LIMIT))
        else $error("Declination result outside one quarter turn.");

    a_setup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        setup_done |-> busy_reg && !s_tready)
        else $error("Angle setup finished while requests were being taken.");

endmodule

// File: bench/tb_equatorial_precession_rotate_unit.sv
// Self-checking testbench of the equatorial precession rotate unit with a bit-true predictor.
`timescale 1ns / 100ps

module tb_equatorial_precession_rotate_unit;

    localparam int STAGES = 30;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 150;
    localparam logic [63:0] INV_TWO_PI = 64'h28BE60DB9391054A;
    localparam longint GAIN = 652032874;
    localparam longint ONE = 1073741824;
    localparam longint POLE_BOUND = 256;

    typedef struct {
        logic [31:0] ra;
        logic [31:0] dec;
        logic        pole;
    } sky_pos_t;

    typedef struct {
        logic [31:0] ra;
        logic [31:0] dec;
        bit          typed;
        sky_pos_t    known;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        span_we = 1'b0;
    logic [31:0] span_centuries = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;

    longint      atan_turns [STAGES];
    logic [31:0] zeta_q, theta_q, z_q;
    longint      sin_theta_q, cos_theta_q;
    sky_pos_t    pending_pos [$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          calm = 1'b0;
    bit          hold_go = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;

    equatorial_precession_rotate_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .span_we(span_we),
        .span_centuries(span_centuries),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #2 clk = ~clk;

    function automatic longint round_shift(input longint v, input int k);
        return (v + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic longint fix_mul(input longint a, input longint b);
        return round_shift(a * b, 30);
    endfunction

    function automatic longint atan_series(input int i);
        logic [63:0]  acc;
        logic [63:0]  term;
        logic [127:0] prod;
        logic [63:0]  turns;
        int           e;
        acc = '0;
        if (i == 0)
        begin
            return 64'd1 << 29;
        end
        for (int n = 0; n < 32; n++)
        begin
            e = i * (2 * n + 1);
            if (e <= 62)
            begin
                term = (64'd1 << (62 - e)) / 64'(2 * n + 1);
                acc = n[0] ? acc - term : acc + term;
            end
        end
        prod = {64'd0, acc} * {64'd0, INV_TWO_PI};
        turns = prod[127:64];
        return longint'((turns + (64'd1 << 29)) >> 30);
    endfunction

    function automatic void rotate_sincos(input logic [31:0] ang, output longint c,
                                          output longint s);
        logic [31:0] a;
        bit          flip;
        longint      x, y, r, nx;
        a = ang;
        flip = 1'b0;
        x = GAIN;
        y = 0;
        if (a >= 32'h4000_0000 && a < 32'hC000_0000)
        begin
            a = a - 32'h8000_0000;
            flip = 1'b1;
        end
        r = longint'($signed(a));
        for (int i = 0; i < STAGES; i++)
        begin
            if (r >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                r = r - atan_turns[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                r = r + atan_turns[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [31:0] vector_turn(input longint xi, input longint yi,
                                                output longint mag);
        longint      x, y, r, nx;
        logic [63:0] base;
        x = xi;
        y = yi;
        r = 0;
        base = '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            base = 64'h8000_0000;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                r = r + atan_turns[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                r = r - atan_turns[i];
            end
            x = nx;
        end
        mag = x;
        vector_turn = 32'(base + 64'(r));
    endfunction

    function automatic logic [31:0] precession_angle(input longint lin, input longint sq,
                                                     input longint cu, input longint s,
                                                     input longint t2, input longint t3);
        longint sum;
        sum = round_shift(lin * s, 32) + round_shift(sq * t2, 32) + round_shift(cu * t3, 32);
        return sum[31:0];
    endfunction

    function automatic void derive_precession(input logic [31:0] span);
        longint s, t2, t3;
        s = longint'($signed(span));
        t2 = longint'((64'(s * s) + 64'h8000_0000) >> 32);
        t3 = round_shift(t2 * s, 24);
        zeta_q = precession_angle(1956569030, 65599307, 3909375, s, t2, t3);
        theta_q = precession_angle(1700434437, -92652180, -9069749, s, t2, t3);
        z_q = precession_angle(1956569030, 237768168, 3987562, s, t2, t3);
        rotate_sincos(theta_q, cos_theta_q, sin_theta_q);
    endfunction

    function automatic sky_pos_t precess_position(input logic [31:0] ra, input logic [31:0] dec);
        sky_pos_t p;
        longint   ca, sa, cd, sd, cda, sdec, xv, yv, mag, hyp, unused;
        longint   dec_s;
        logic [31:0] ra_t;
        rotate_sincos(ra + zeta_q, ca, sa);
        rotate_sincos(dec, cd, sd);
        cda = fix_mul(ca, cd);
        sdec = fix_mul(cda, sin_theta_q) + fix_mul(cos_theta_q, sd);
        xv = fix_mul(cda, cos_theta_q) - fix_mul(sin_theta_q, sd);
        yv = fix_mul(sa, cd);
        if (xv <= POLE_BOUND && xv >= -POLE_BOUND && yv <= POLE_BOUND && yv >= -POLE_BOUND)
        begin
            p.ra = z_q;
            p.dec = sdec >= 0 ? 32'(ONE) : 32'(-ONE);
            p.pole = 1'b1;
            return p;
        end
        ra_t = vector_turn(xv, yv, mag);
        hyp = fix_mul(mag, GAIN);
        dec_s = longint'($signed(vector_turn(hyp, sdec, unused)));
        if (dec_s > ONE)
        begin
            dec_s = ONE;
        end
        if (dec_s < -ONE)
        begin
            dec_s = -ONE;
        end
        p.ra = ra_t + z_q;
        p.dec = dec_s[31:0];
        p.pole = 1'b0;
        return p;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %0s: got %h expected %h at cycle %0d", field, got, want, cycle_count);
        error_count++;
    endtask

    task automatic send_position(input logic [31:0] ra, input logic [31:0] dec, input bit typed,
                                 input sky_pos_t known);
        while (!calm && $urandom_range(99) < 7)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {dec, ra};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        pending_pos.push_back(typed ? known : precess_position(ra, dec));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_pos.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_span(input logic [31:0] v);
        wait_drained();
        span_we <= 1'b1;
        span_centuries <= v;
        @(negedge clk);
        span_we <= 1'b0;
        derive_precession(v);
    endtask

    function automatic logic [31:0] random_dec();
        return 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** equatorial_precession_rotate_unit: FAILED **");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_go && !hold_done)
        begin
            m_tready <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else
        begin
            m_tready <= calm || $urandom_range(99) >= 7;
        end
    end

    always @(posedge clk)
    begin
        sky_pos_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pos.size() == 0)
            begin
                report_mismatch("unexpected result", m_tdata[31:0], '0);
            end
            else
            begin
                want = pending_pos.pop_front();
                if (m_tdata[31:0] !== want.ra)
                begin
                    report_mismatch("ra_out", m_tdata[31:0], want.ra);
                end
                if (m_tdata[63:32] !== want.dec)
                begin
                    report_mismatch("dec_out", m_tdata[63:32], want.dec);
                end
                if (m_tuser[0] !== want.pole)
                begin
                    report_mismatch("at_pole", 32'(m_tuser[0]), 32'(want.pole));
                end
            end
        end
    end

    initial
    begin
        stim_row_t   rows [$];
        logic [31:0] spans [6];
        sky_pos_t    none;
        none = '{ra: '0, dec: '0, pole: 1'b0};
        for (int i = 0; i < STAGES; i++)
        begin
            atan_turns[i] = atan_series(i);
        end
        zeta_q = '0;
        theta_q = '0;
        z_q = '0;
        sin_theta_q = 0;
        cos_theta_q = ONE;
        rows.push_back('{32'h0000_0000, 32'h0000_0000, 1'b0, none});
        rows.push_back('{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, none});
        rows.push_back('{32'h0000_0000, 32'h4000_0000, 1'b1, '{32'h0, 32'h4000_0000, 1'b1}});
        rows.push_back('{32'h1234_5678, 32'hC000_0000, 1'b1, '{32'h0, 32'hC000_0000, 1'b1}});
        rows.push_back('{32'h8000_0000, 32'h0000_0000, 1'b0, none});
        rows.push_back('{32'h4000_0000, 32'h3FFF_FFFF, 1'b0, none});
        rows.push_back('{32'hC000_0000, 32'hC000_0001, 1'b0, none});
        rows.push_back('{32'h7FFF_FFFF, 32'h2000_0000, 1'b0, none});
        rows.push_back('{32'hAAAA_AAAA, 32'hE000_0000, 1'b0, none});
        rows.push_back('{32'h5555_5555, 32'h1555_5555, 1'b0, none});
        rows.push_back('{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, none});
        rows.push_back('{32'hFFFF_0000, 32'h0000_0001, 1'b0, none});
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        foreach (rows[i])
        begin
            send_position(rows[i].ra, rows[i].dec, rows[i].typed, rows[i].known);
        end
        spans[0] = 32'h7FFF_FFFF;
        spans[1] = 32'h8000_0000;
        spans[2] = 32'h0100_0000;
        spans[3] = 32'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
        spans[4] = $urandom;
        spans[5] = 32'hFF00_0000;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_span(spans[ph]);
            calm = (ph == 3);
            send_position(32'h0000_0000, 32'h4000_0000, 1'b0, none);
            send_position(32'hFFFF_FFFF, 32'hC000_0000, 1'b0, none);
            for (int n = 0; n < 140; n++)
            begin
                if (ph == 1 && n == 20)
                begin
                    hold_go = 1'b1;
                end
                if (ph == 4 && n == 70)
                begin
                    wait_drained();
                end
                send_position($urandom, random_dec(), 1'b0, none);
            end
            calm = 1'b0;
        end
        wait_drained();
        if (error_count == 0)
        begin
            $display("** equatorial_precession_rotate_unit: PASSED **");
        end
        else
        begin
            $display("** equatorial_precession_rotate_unit: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/epr_pkg.sv
rtl/epr_cordic_cell.sv
rtl/epr_cordic_chain.sv
rtl/epr_angle_setup.sv
rtl/equatorial_precession_rotate_unit.sv
bench/tb_equatorial_precession_rotate_unit.sv
